>>> sv/pvm_pkg.sv
// ---------------------------------------------------------------------------
// pvm_pkg: shared types and constants of the pcm voice mixer
// operation codes, channel kinds, slot descriptor type and defaults
// ---------------------------------------------------------------------------
`default_nettype none
package pvm_pkg;

    localparam int DEF_SLOTS_PER_SIDE = 8;
    localparam int DEF_SAMPLE_WORDS   = 4096;
    localparam int WIDE_TOP_SHIFT     = 24;
    localparam int NARROW_TOP_SHIFT   = 8;
    localparam int PAIR_STEP          = 2;
    localparam int IDX_W              = 18;
    localparam int MAX_RSHIFT         = 4;
    // per-side level sum, wide enough for 32 slots of 255
    localparam int SUM_W              = 13;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_START = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CK_MONO_L   = 3'd0,
        CK_MONO_R   = 3'd1,
        CK_STEREO_L = 3'd2,
        CK_STEREO_R = 3'd3,
        CK_MONO_LR  = 3'd4,
        CK_STEREO   = 3'd5
    } t_kind;

    // copy of a sound's fields held by one slot
    typedef struct packed {
        logic [11:0] base;
        logic [14:0] len;
        logic        wide;
        logic [2:0]  rshift;
        logic        pair;
        logic [3:0]  atten;
        logic        loop_en;
    } t_desc;

    // divider control between sequencer and divider
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [7:0]       divisor;
    } t_div_req;

endpackage
`default_nettype wire

>>> sv/pvm_divider.sv
// ---------------------------------------------------------------------------
// pvm_divider: shared radix-2 restoring divider
// one quotient bit per cycle, 13-bit dividend, 8-bit divisor
// ---------------------------------------------------------------------------
`default_nettype none
module pvm_divider
    import pvm_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_div_req     i_req,
    output logic              o_busy,
    output logic [SUM_W-1:0]  o_quot
);
    logic [3:0]       r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic [SUM_W-1:0] r_q, n_q;
    logic [8:0]       r_rem, n_rem;
    logic [7:0]       r_dv, n_dv;
    logic [8:0]       w_trial;

    always_comb begin
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_q    = r_q;
        n_rem  = r_rem;
        n_dv   = r_dv;
        w_trial = {r_rem[7:0], r_q[SUM_W-1]};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = 4'd0;
            n_q    = i_req.dividend;
            n_rem  = 9'd0;
            n_dv   = i_req.divisor;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_dv}) begin
                n_rem = w_trial - {1'b0, r_dv};
                n_q   = {r_q[SUM_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_q   = {r_q[SUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 4'd1;
            if (r_cnt == 4'(SUM_W - 1)) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 4'd0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_dv  <= n_dv;
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;
endmodule
`default_nettype wire

>>> sv/pvm_sample_ram.sv
// ---------------------------------------------------------------------------
// pvm_sample_ram: sample word memory, one write or one read per cycle
// read data registered
// ---------------------------------------------------------------------------
`default_nettype none
module pvm_sample_ram #(
    parameter int SAMPLE_WORDS = 4096,
    parameter int AW           = $clog2(SAMPLE_WORDS)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_addr,
    input  wire logic [31:0]   i_wdata,
    output logic [31:0]        o_rdata
);
    logic [31:0] r_mem [SAMPLE_WORDS];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

>>> sv/pcm_voice_mixer_core.sv
// ---------------------------------------------------------------------------
// pcm_voice_mixer_core: multi-voice pcm sample mixer
// sample ram, slot table and a sequencer that walks the slots on a tick
// ---------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  s_axis    in   tvalid/tready        operation, mem/start fields in tdata
//  m_axis    out  tvalid/tready        status, left_level, right_level
//  cfg       in   i_cfg_we             master_volume_divisor
//
//  a write or start request passes the start and output states before its result is valid
//  a tick visits each active slot in the scan, ram read and accumulate states
//  and each idle slot in the scan state only; per side the average and then
//  the volume division run in the shared divider (no average when no slot is active)
//  reset clears the slot table and sets the volume to 1; the sample ram is not cleared
//  one request at a time; the result sits in an output register until taken
// ---------------------------------------------------------------------------
`default_nettype none
module pcm_voice_mixer_core
    import pvm_pkg::*;
#(
    parameter int SLOTS_PER_SIDE = DEF_SLOTS_PER_SIDE,
    parameter int SAMPLE_WORDS   = DEF_SAMPLE_WORDS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata lsb up: operation[1:0] mem_addr[13:2] mem_data[45:14]
    // channel_kind[48:46] base_word[60:49] length_bytes[75:61]
    // wide_samples[76] rate_shift[79:77] interleaved_pair[80]
    // atten_shift[84:81] loop_sound[85], zero fill to 88
    input  wire logic [87:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata lsb up: status[0] left_level[8:1] right_level[16:9], zero fill
    output logic [23:0]      m_axis_tdata,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_wdata
);
    localparam int NS  = 2 * SLOTS_PER_SIDE;
    localparam int SW  = $clog2(NS);
    localparam int AW  = $clog2(SAMPLE_WORDS);
    localparam int CW  = $clog2(SLOTS_PER_SIDE + 1);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_START = 10'b0000000010,
        ST_SCAN  = 10'b0000000100,
        ST_RD    = 10'b0000001000,
        ST_ACC   = 10'b0000010000,
        ST_DIV1  = 10'b0000100000,
        ST_WAIT1 = 10'b0001000000,
        ST_DIV2  = 10'b0010000000,
        ST_WAIT2 = 10'b0100000000,
        ST_OUT   = 10'b1000000000
    } t_state;

    t_state r_st;
    logic [87:0] r_in;
    logic [7:0]  r_vol;
    logic [NS-1:0] r_valid;
    t_desc       r_desc [NS];
    logic [IDX_W-1:0] r_idx [NS];
    logic [SW-1:0] r_k;
    logic [SUM_W-1:0] r_sum;
    logic [CW-1:0] r_num;
    logic        r_side;
    logic [7:0]  r_left;
    logic        r_wait;
    logic [16:0] r_res;
    logic        r_ovalid;
    t_div_req    w_div;
    logic        w_dbusy;
    logic [SUM_W-1:0] w_quot;

    // unpacked request fields
    logic [1:0]  f_op;
    logic [11:0] f_addr, f_base;
    logic [31:0] f_data;
    logic [2:0]  f_kind, f_rs;
    t_desc       f_desc;
    assign f_op   = r_in[1:0];
    assign f_addr = r_in[13:2];
    assign f_data = r_in[45:14];
    assign f_kind = r_in[48:46];
    assign f_base = r_in[60:49];
    assign f_rs   = r_in[79:77];
    always_comb begin
        f_desc.base    = f_base;
        f_desc.len     = r_in[75:61];
        f_desc.wide    = r_in[76];
        f_desc.rshift  = (f_rs > 3'(MAX_RSHIFT)) ? 3'(MAX_RSHIFT) : f_rs;
        f_desc.pair    = r_in[80];
        f_desc.atten   = r_in[84:81];
        f_desc.loop_en = r_in[85];
    end

    // free slot search per side: first and second free and count
    logic [SLOTS_PER_SIDE-1:0] w_freeL, w_freeR;
    logic [CW-1:0] w_cntL, w_cntR;
    assign w_freeL = ~r_valid[SLOTS_PER_SIDE-1:0];
    assign w_freeR = ~r_valid[NS-1:SLOTS_PER_SIDE];
    assign w_cntL  = CW'($countones(w_freeL));
    assign w_cntR  = CW'($countones(w_freeR));

    function automatic logic [SLOTS_PER_SIDE-1:0] first_one(
        input logic [SLOTS_PER_SIDE-1:0] v);
        logic [SLOTS_PER_SIDE-1:0] r;
        r = v & (~v + SLOTS_PER_SIDE'(1));
        return r;
    endfunction

    logic [SLOTS_PER_SIDE-1:0] w_l1, w_l2, w_r1, w_r2;
    assign w_l1 = first_one(w_freeL);
    assign w_l2 = first_one(w_freeL & ~w_l1);
    assign w_r1 = first_one(w_freeR);
    assign w_r2 = first_one(w_freeR & ~w_r1);

    // start refused when the needed slots are not free
    logic w_refuse;
    always_comb begin
        w_refuse = 1'b0;
        if (f_op == OP_START) begin
            unique case (f_kind)
                CK_MONO_L:   w_refuse = (w_cntL < CW'(1));
                CK_MONO_R:   w_refuse = (w_cntR < CW'(1));
                CK_STEREO_L: w_refuse = ((CW+1)'(w_cntL) < (CW+1)'(2));
                CK_STEREO_R: w_refuse = ((CW+1)'(w_cntR) < (CW+1)'(2));
                CK_MONO_LR, CK_STEREO:
                    w_refuse = (w_cntL < CW'(1)) || (w_cntR < CW'(1));
                default:     w_refuse = 1'b0;
            endcase
        end
    end

    // current slot for the tick sequence
    t_desc w_cd;
    logic [IDX_W-1:0] w_ci;
    logic [IDX_W-1:0] w_sidx;
    logic [AW-1:0] w_raddr;
    assign w_cd   = r_desc[r_k];
    assign w_ci   = r_idx[r_k];
    assign w_sidx = w_ci >> w_cd.rshift;
    always_comb begin
        if (w_cd.wide) w_raddr = AW'({6'd0, w_cd.base} + 18'(w_sidx));
        else           w_raddr = AW'({6'd0, w_cd.base} + 18'(w_sidx >> 1));
    end

    logic        w_ram_we;
    logic [AW-1:0] w_ram_addr;
    logic [31:0] w_rdata;
    assign w_ram_we   = (r_st == ST_START) && (f_op == OP_WRITE);
    assign w_ram_addr = w_ram_we ? AW'(f_addr) : w_raddr;

    pvm_sample_ram #(.SAMPLE_WORDS(SAMPLE_WORDS), .AW(AW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_addr (w_ram_addr),
        .i_wdata(f_data),
        .o_rdata(w_rdata)
    );

    // sample value of current slot
    logic [7:0] w_top, w_val;
    logic [15:0] w_half;
    always_comb begin
        w_half = w_sidx[0] ? w_rdata[31:16] : w_rdata[15:0];
        if (w_cd.wide) w_top = w_rdata[WIDE_TOP_SHIFT +: 8];
        else           w_top = w_half[NARROW_TOP_SHIFT +: 8];
        w_val = (w_top ^ 8'h80) >> w_cd.atten;
    end

    // end of sound check
    logic [13:0] w_samples;
    logic [IDX_W+4:0] w_end;
    logic w_atend;
    assign w_samples = w_cd.wide ? 14'(w_cd.len >> 2) : 14'(w_cd.len >> 1);
    assign w_end     = (IDX_W+5)'(w_samples) << w_cd.rshift;
    assign w_atend   = (IDX_W+5)'(w_ci) >= w_end;

    logic w_last;
    assign w_last = (r_k == SW'(NS - 1)) ||
                    (r_k == SW'(SLOTS_PER_SIDE - 1));

    logic [SUM_W-1:0] w_avg;
    assign w_avg = w_quot;

    always_comb begin
        w_div.start    = 1'b0;
        w_div.dividend = r_sum;
        w_div.divisor  = {{(8-CW){1'b0}}, r_num};
        if (r_st == ST_DIV1) begin
            w_div.start = (r_num != '0);
        end else if (r_st == ST_DIV2) begin
            w_div.start    = 1'b1;
            w_div.dividend = r_sum;
            w_div.divisor  = (r_vol == 8'd0) ? 8'd1 : r_vol;
        end
    end

    pvm_divider u_div (
        .i_clk (i_clk),
        .i_rst_n(i_rst_n),
        .i_req (w_div),
        .o_busy(w_dbusy),
        .o_quot(w_quot)
    );

    assign s_axis_tready = (r_st == ST_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'd0, r_res};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_vol    <= 8'd1;
            r_valid  <= '0;
            r_ovalid <= 1'b0;
            r_wait   <= 1'b0;
            for (int i = 0; i < NS; i++) r_idx[i] <= '0;
        end else begin
            if (i_cfg_we) r_vol <= i_cfg_wdata;
            if (r_st == ST_OUT) r_ovalid <= 1'b1;
            else if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_st)
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_in <= s_axis_tdata;
                        r_st <= ST_START;
                    end
                end
                ST_START: begin
                    r_res <= {16'd0, w_refuse};
                    r_k   <= '0;
                    r_sum <= '0;
                    r_num <= '0;
                    r_side <= 1'b0;
                    r_left <= '0;
                    r_st  <= (f_op == OP_TICK) ? ST_SCAN : ST_OUT;
                    if (f_op == OP_START && !w_refuse) begin
                        unique case (f_kind)
                            CK_MONO_L: begin
                                for (int i = 0; i < SLOTS_PER_SIDE; i++)
                                    if (w_l1[i]) begin
                                        r_valid[i] <= 1'b1;
                                        r_desc[i] <= f_desc;
                                        r_idx[i] <= '0;
                                    end
                            end
                            CK_MONO_R: begin
                                for (int i = 0; i < SLOTS_PER_SIDE; i++)
                                    if (w_r1[i]) begin
                                        r_valid[SLOTS_PER_SIDE+i] <= 1'b1;
                                        r_desc[SLOTS_PER_SIDE+i] <= f_desc;
                                        r_idx[SLOTS_PER_SIDE+i] <= '0;
                                    end
                            end
                            CK_STEREO_L: begin
                                for (int i = 0; i < SLOTS_PER_SIDE; i++)
                                    if (w_l1[i] || w_l2[i]) begin
                                        r_valid[i] <= 1'b1;
                                        r_desc[i] <= f_desc;
                                        r_idx[i] <= IDX_W'(w_l2[i]);
                                    end
                            end
                            CK_STEREO_R: begin
                                for (int i = 0; i < SLOTS_PER_SIDE; i++)
                                    if (w_r1[i] || w_r2[i]) begin
                                        r_valid[SLOTS_PER_SIDE+i] <= 1'b1;
                                        r_desc[SLOTS_PER_SIDE+i] <= f_desc;
                                        r_idx[SLOTS_PER_SIDE+i] <= IDX_W'(w_r2[i]);
                                    end
                            end
                            CK_MONO_LR, CK_STEREO: begin
                                for (int i = 0; i < SLOTS_PER_SIDE; i++) begin
                                    if (w_l1[i]) begin
                                        r_valid[i] <= 1'b1;
                                        r_desc[i] <= f_desc;
                                        r_idx[i] <= '0;
                                    end
                                    if (w_r1[i]) begin
                                        r_valid[SLOTS_PER_SIDE+i] <= 1'b1;
                                        r_desc[SLOTS_PER_SIDE+i] <= f_desc;
                                        r_idx[SLOTS_PER_SIDE+i] <=
                                            IDX_W'(f_kind == CK_STEREO);
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SCAN: begin
                    // skip idle slots, else issue ram read
                    if (r_valid[r_k]) r_st <= ST_RD;
                    else if (w_last) r_st <= ST_DIV1;
                    else r_k <= r_k + SW'(1);
                end
                ST_RD: r_st <= ST_ACC;
                ST_ACC: begin
                    r_sum <= r_sum + SUM_W'(w_val);
                    r_num <= r_num + CW'(1);
                    if (w_atend && !w_cd.loop_en) begin
                        r_valid[r_k] <= 1'b0;
                        r_idx[r_k]   <= '0;
                    end else if (w_atend) begin
                        r_idx[r_k] <= w_cd.pair ? IDX_W'(PAIR_STEP) : IDX_W'(1);
                    end else begin
                        r_idx[r_k] <= w_ci + (w_cd.pair ? IDX_W'(PAIR_STEP) : IDX_W'(1));
                    end
                    r_st <= w_last ? ST_DIV1 : ST_SCAN;
                    if (!w_last) r_k <= r_k + SW'(1);
                end
                ST_DIV1: begin
                    r_wait <= 1'b1;
                    r_st   <= ST_WAIT1;
                end
                ST_WAIT1: begin
                    r_wait <= 1'b0;
                    if (r_num == '0) r_st <= ST_DIV2;
                    else if (!w_dbusy && !r_wait) begin
                        r_sum <= w_avg;
                        r_st  <= ST_DIV2;
                    end
                end
                ST_DIV2: begin
                    r_wait <= 1'b1;
                    r_st   <= ST_WAIT2;
                end
                ST_WAIT2: begin
                    r_wait <= 1'b0;
                    if (!w_dbusy && !r_wait) begin
                        if (!r_side) begin
                            r_left <= w_quot[7:0];
                            r_side <= 1'b1;
                            r_sum  <= '0;
                            r_num  <= '0;
                            r_k    <= r_k + SW'(1);
                            r_st   <= ST_SCAN;
                        end else begin
                            r_res <= {w_quot[7:0], r_left, 1'b0};
                            r_st  <= ST_OUT;
                        end
                    end
                end
                ST_OUT: begin
                    r_st <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    // no new request while a result is pending
    a_no_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !s_axis_tready) else $error("accept while result pending");
    // result appears only after the output step
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_st == ST_OUT)) else $error("stray result");
    // divider never restarted while busy
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.start |-> !w_dbusy) else $error("divider overrun");
endmodule
`default_nettype wire

>>> tb/tb_pcm_voice_mixer_core.sv
// ---------------------------------------------------------------------------
// tb_pcm_voice_mixer_core: self-checking bench for the pcm voice mixer
// table-driven directed requests, then random write/start/tick traffic,
// each response compared against a behavioral mixer model
// ---------------------------------------------------------------------------
`default_nettype none
module tb_pcm_voice_mixer_core;
    import pvm_pkg::*;

    localparam int NSIDE = DEF_SLOTS_PER_SIDE;
    localparam int NWORDS = DEF_SAMPLE_WORDS;
    localparam int IDLE_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic [7:0]  i_cfg_wdata = '0;

    pcm_voice_mixer_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // one request as the fields travel in tdata
    typedef struct {
        t_op         op;
        logic [11:0] addr;
        logic [31:0] data;
        logic [2:0]  kind;
        t_desc       d;
    } t_req;

    typedef struct packed {
        logic       status;
        logic [7:0] left;
        logic [7:0] right;
    } t_resp;

    // mixer model state
    logic [31:0]      mdl_ram [NWORDS];
    bit               mdl_ram_ok [NWORDS];
    bit               mdl_valid [2*NSIDE];
    t_desc            mdl_desc [2*NSIDE];
    logic [IDX_W-1:0] mdl_idx [2*NSIDE];
    logic [7:0]       mdl_vol;

    t_resp pending_resp [$];
    int    n_fail = 0;
    int    idle_cycles = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        n_fail++;
    endtask

    function automatic int free_slots(input int side);
        int n = 0;
        for (int i = 0; i < NSIDE; i++) if (!mdl_valid[side*NSIDE+i]) n++;
        return n;
    endfunction

    function automatic void claim_slot(input int side, input t_desc d, input int start);
        for (int i = 0; i < NSIDE; i++) begin
            if (!mdl_valid[side*NSIDE+i]) begin
                mdl_valid[side*NSIDE+i] = 1;
                mdl_desc[side*NSIDE+i] = d;
                mdl_idx[side*NSIDE+i] = IDX_W'(start);
                return;
            end
        end
    endfunction

    // tick: average of attenuated top bytes of every live slot on one side, divided by div
    function automatic logic [7:0] mix_one_side(input int side, input int div);
        int sum = 0, num = 0;
        int k, sidx, samples, lim;
        logic [31:0] w;
        logic [7:0] top;
        for (int i = 0; i < NSIDE; i++) begin
            k = side*NSIDE + i;
            if (mdl_valid[k]) begin
                sidx = mdl_idx[k] >> mdl_desc[k].rshift;
                if (mdl_desc[k].wide) begin
                    w = mdl_ram[(mdl_desc[k].base + sidx) % NWORDS];
                    top = w[31:24];
                end else begin
                    w = mdl_ram[(mdl_desc[k].base + (sidx >> 1)) % NWORDS];
                    if (sidx & 1) w = w >> 16;
                    top = w[15:8];
                end
                sum += (top ^ 8'h80) >> mdl_desc[k].atten;
                num++;
                samples = mdl_desc[k].wide ? (mdl_desc[k].len >> 2) : (mdl_desc[k].len >> 1);
                lim = samples << mdl_desc[k].rshift;
                if (mdl_idx[k] >= lim) begin
                    mdl_idx[k] = '0;
                    if (!mdl_desc[k].loop_en) begin
                        mdl_valid[k] = 0;
                        continue;
                    end
                end
                mdl_idx[k] = mdl_idx[k] + IDX_W'(mdl_desc[k].pair ? PAIR_STEP : 1);
            end
        end
        if (num != 0) sum /= num;
        return 8'(sum / div);
    endfunction

    function automatic t_resp predict_mix(input t_req r);
        t_resp o = '{0, 0, 0};
        t_desc d = r.d;
        int div;
        if (d.rshift > MAX_RSHIFT) d.rshift = 3'(MAX_RSHIFT);
        case (r.op)
            OP_WRITE: begin
                mdl_ram[r.addr] = r.data;
                mdl_ram_ok[r.addr] = 1;
            end
            OP_START: begin
                case (r.kind)
                    CK_MONO_L, CK_MONO_R: begin
                        if (free_slots(r.kind) < 1) o.status = 1;
                        else claim_slot(r.kind, d, 0);
                    end
                    CK_STEREO_L, CK_STEREO_R: begin
                        if (free_slots(r.kind - 2) < 2) o.status = 1;
                        else begin
                            claim_slot(r.kind - 2, d, 0);
                            claim_slot(r.kind - 2, d, 1);
                        end
                    end
                    CK_MONO_LR, CK_STEREO: begin
                        if (free_slots(0) < 1 || free_slots(1) < 1) o.status = 1;
                        else begin
                            claim_slot(0, d, 0);
                            claim_slot(1, d, r.kind == CK_STEREO ? 1 : 0);
                        end
                    end
                    default: ;
                endcase
            end
            OP_TICK: begin
                div = (mdl_vol == 0) ? 1 : mdl_vol;
                o.left = mix_one_side(0, div);
                o.right = mix_one_side(1, div);
            end
            default: ;
        endcase
        return o;
    endfunction

    // every word a sound can reach must already be written
    function automatic bit sound_reads_ok(input t_desc d);
        int words;
        words = d.len >> 2;
        // index runs to end + 1 (stereo second slot) including pair step
        words = words + 2;
        for (int i = 0; i <= words; i++)
            if (!mdl_ram_ok[(d.base + i) % NWORDS]) return 0;
        return 1;
    endfunction

    // response side: random stall, compare with oldest prediction
    initial begin
        t_resp want;
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = $urandom_range(0, 3);
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk iff m_axis_tvalid);
            if (pending_resp.size() == 0) begin
                report_mismatch("unexpected response", int'(m_axis_tdata), 0);
            end else begin
                want = pending_resp.pop_front();
                if (m_axis_tdata[0] !== want.status)
                    report_mismatch("status", m_axis_tdata[0], want.status);
                if (m_axis_tdata[8:1] !== want.left)
                    report_mismatch("left_level", m_axis_tdata[8:1], want.left);
                if (m_axis_tdata[16:9] !== want.right)
                    report_mismatch("right_level", m_axis_tdata[16:9], want.right);
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // one request through the slave side, then queue its prediction
    task automatic send_request(input t_req r, input bit has_want, input t_resp want);
        t_resp p;
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata <= {2'b0, r.d.loop_en, r.d.atten, r.d.pair, r.d.rshift, r.d.wide,
                         r.d.len, r.d.base, r.kind, r.data, r.addr, r.op};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk iff s_axis_tready);
        p = predict_mix(r);
        if (has_want && p != want)
            report_mismatch("directed row", int'(p), int'(want));
        pending_resp.push_back(p);
    endtask

    task automatic drain_and_config(input logic [7:0] vol);
        s_axis_tvalid <= 1'b0;
        wait (pending_resp.size() == 0);
        repeat (200) @(posedge i_clk);
        i_cfg_wdata <= vol;
        i_cfg_we <= 1'b1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mdl_vol = vol;
    endtask

    function automatic t_req make_req(input t_op op, input int addr, input logic [31:0] data,
                                      input int kind, input int base, input int len,
                                      input bit wide, input int rs, input bit pair,
                                      input int att, input bit lp);
        t_req r;
        r.op = op; r.addr = 12'(addr); r.data = data; r.kind = 3'(kind);
        r.d.base = 12'(base); r.d.len = 15'(len); r.d.wide = wide; r.d.rshift = 3'(rs);
        r.d.pair = pair; r.d.atten = 4'(att); r.d.loop_en = lp;
        return r;
    endfunction

    t_req  dir_tab [$];
    bit    dir_has [$];
    t_resp dir_want [$];

    function automatic void add_row(input t_req r, input bit h, input t_resp w);
        dir_tab.push_back(r); dir_has.push_back(h); dir_want.push_back(w);
    endfunction

    initial begin
        t_req r;
        t_resp none;
        t_resp ok = '{0, 0, 0};
        int sel, base;
        for (int i = 0; i < NWORDS; i++) begin
            mdl_ram_ok[i] = 0; mdl_ram[i] = '0;
        end
        for (int k = 0; k < 2*NSIDE; k++) begin
            mdl_valid[k] = 0; mdl_idx[k] = '0; mdl_desc[k] = '0;
        end
        mdl_vol = 1;
        none = ok;

        // directed: empty tick and no-op, ram at 0..15 and 0xFFF full of extremes, then starts and ticks
        add_row(make_req(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, ok); // empty tick
        add_row(make_req(OP_NONE, 12'hFFF, '1, 7, 0, 0, 0, 0, 0, 0, 0), 1, ok);
        for (int i = 0; i < 16; i++)
            add_row(make_req(OP_WRITE, i, (i & 1) ? 32'h7FFF_8000 : 32'hFFFF_0000,
                             0, 0, 0, 0, 0, 0, 0, 0), 1, ok);
        add_row(make_req(OP_WRITE, 12'hFFF, 32'h8000_7FFF, 0, 0, 0, 0, 0, 0, 0, 0), 1, ok);
        add_row(make_req(OP_START, 0, 0, 6, 0, 8, 0, 0, 0, 0, 0), 1, ok); // bad kind
        add_row(make_req(OP_START, 0, 0, CK_MONO_L, 12'hFFF, 4, 1, 7, 1, 0, 0), 0, none);
        add_row(make_req(OP_START, 0, 0, CK_STEREO, 0, 8, 0, 1, 1, 8, 1), 0, none);
        add_row(make_req(OP_START, 0, 0, CK_MONO_LR, 2, 0, 1, 0, 0, 15, 0), 0, none);
        add_row(make_req(OP_START, 0, 0, CK_STEREO_R, 4, 12, 0, 0, 0, 1, 1), 0, none);
        add_row(make_req(OP_START, 0, 0, CK_STEREO_L, 4, 16, 1, 2, 0, 2, 0), 0, none);
        add_row(make_req(OP_START, 0, 0, CK_MONO_R, 6, 2, 0, 4, 1, 0, 1), 0, none);
        for (int i = 0; i < 4; i++)
            add_row(make_req(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        drain_and_config(8'd1);

        foreach (dir_tab[i]) send_request(dir_tab[i], dir_has[i], dir_want[i]);

        // fill the slot table until starts get refused
        for (int i = 0; i < 10; i++)
            send_request(make_req(OP_START, 0, 0, CK_MONO_LR, 0, 4, 0, 0, 0, 0, 1), 0, none);
        for (int i = 0; i < 5; i++)
            send_request(make_req(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);

        // random phases over several volume settings
        for (int ph = 0; ph < 5; ph++) begin
            drain_and_config(ph == 0 ? 8'd255 : ph == 1 ? 8'd0 :
                             ph == 2 ? 8'd1 : 8'($urandom_range(2, 254)));
            for (int n = 0; n < 130; n++) begin
                sel = $urandom_range(0, 9);
                if (sel < 3) begin
                    r = make_req(OP_WRITE, $urandom_range(0, NWORDS-1), $urandom(),
                                 0, 0, 0, 0, 0, 0, 0, 0);
                    if ($urandom_range(0, 3) == 0) r.addr = 12'($urandom_range(0, 63));
                end else if (sel < 5) begin
                    base = ($urandom_range(0, 1)) ? $urandom_range(0, 40) :
                                                    $urandom_range(0, NWORDS-1);
                    r = make_req(OP_START, 0, 0, $urandom_range(0, 7), base,
                                 ($urandom_range(0, 15) == 0) ? $urandom_range(0, 32767) :
                                                                $urandom_range(0, 64),
                                 $urandom_range(0, 1), $urandom_range(0, 7),
                                 $urandom_range(0, 1), $urandom_range(0, 15),
                                 $urandom_range(0, 1));
                    r.data = $urandom(); r.addr = 12'($urandom());
                    // skip sounds that would play unwritten ram or run very long
                    if (r.d.len > 80 || !sound_reads_ok(r.d)) r.d.len = '0;
                    if (!sound_reads_ok(r.d)) begin
                        r.op = OP_WRITE; r.addr = 12'(base);
                    end
                end else if (sel < 9) begin
                    r = make_req(OP_TICK, $urandom(), $urandom(), $urandom(), $urandom(),
                                 $urandom(), 0, 0, 0, 0, 0);
                end else begin
                    r = make_req(OP_NONE, $urandom(), $urandom(), $urandom(), 0, 0,
                                 0, 0, 0, 0, 0);
                end
                send_request(r, 0, none);
                if (n == 60) begin
                    s_axis_tvalid <= 1'b0;
                    wait (pending_resp.size() == 0);
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        wait (pending_resp.size() == 0);
        repeat (200) @(posedge i_clk);
        if (n_fail == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire

>>> files.f
sv/pvm_pkg.sv
sv/pvm_divider.sv
sv/pvm_sample_ram.sv
sv/pcm_voice_mixer_core.sv
tb/tb_pcm_voice_mixer_core.sv
